// ===== src/bwa_pkg.sv =====
package bwa_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int COUNT_BITS    = 24;
   localparam int PERIOD_BITS   = 32;
   localparam int INTERVAL_BITS = COUNT_BITS + PERIOD_BITS;
   localparam int DET_BITS      = SAMPLE_BITS + 5;
   localparam int DIV_CNT_BITS  = $clog2(INTERVAL_BITS);
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = PERIOD_BITS;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [COUNT_BITS-1:0]         count_type;
   typedef logic [PERIOD_BITS-1:0]        period_type;
   typedef logic [INTERVAL_BITS-1:0]      interval_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam count_type  COUNT_MAX  = '1;

   localparam count_type  WINDOW_RESET   = COUNT_BITS'(1000);
   localparam period_type PERIOD_RESET   = PERIOD_BITS'(1000000);
   localparam period_type PERIOD_DEFAULT = PERIOD_BITS'(1000000);

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_SAMPLES   = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SAMPLE_PERIOD_NS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DSTART,
      ST_DIV,
      ST_EMIT
   } core_state_type;

   typedef struct packed {
      logic         start;
      interval_type dividend;
      count_type    divisor;
   } div_req_type;

   typedef struct packed {
      logic         done;
      interval_type quotient;
   } div_rsp_type;

endpackage

// ===== src/bwa_req_if.sv =====
interface bwa_req_if;
   import bwa_pkg::*;

   logic       valid;
   logic       ready;
   sample_type voltage_sample;

   modport source (output valid, output voltage_sample, input ready);
   modport sink (input valid, input voltage_sample, output ready);
endinterface

// ===== src/bwa_rsp_if.sv =====
interface bwa_rsp_if;
   import bwa_pkg::*;

   logic         valid;
   logic         ready;
   sample_type   window_min;
   sample_type   window_max;
   interval_type burst_interval_ns;

   modport source (output valid, output window_min, output window_max,
                   output burst_interval_ns, input ready);
   modport sink (input valid, input window_min, input window_max,
                 input burst_interval_ns, output ready);
endinterface

// ===== src/bwa_queue.sv =====
module bwa_queue (
   input  logic     clock,
   input  logic     reset,
   bwa_req_if.sink   in_word,
   bwa_req_if.source out_word
);
   import bwa_pkg::*;

   sample_type  data_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign in_word.ready         = (count_ff != 2'd2);
   assign out_word.valid        = (count_ff != 2'd0);
   assign out_word.voltage_sample = data_ff[rd_ptr_ff];

   assign push = in_word.valid && in_word.ready;
   assign pop  = out_word.valid && out_word.ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= in_word.voltage_sample;
      end
   end

endmodule

// ===== src/bwa_div.sv =====
module bwa_div (
   input  logic                clock,
   input  logic                reset,
   input  bwa_pkg::div_req_type req,
   output bwa_pkg::div_rsp_type rsp
);
   import bwa_pkg::*;

   localparam logic [DIV_CNT_BITS-1:0] LAST_STEP = DIV_CNT_BITS'(INTERVAL_BITS - 1);

   logic                    busy_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   count_type               rem_ff, rem_in;
   interval_type            quo_ff, quo_in;
   count_type               dvs_ff;
   logic [COUNT_BITS:0]     trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial = {rem_ff, quo_ff[INTERVAL_BITS-1]};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = COUNT_BITS'(trial - {1'b0, dvs_ff});
         quo_in = {quo_ff[INTERVAL_BITS-2:0], 1'b1};
      end else begin
         rem_in = COUNT_BITS'(trial);
         quo_in = {quo_ff[INTERVAL_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         quo_ff <= req.dividend;
         dvs_ff <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign rsp.done     = !busy_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== src/bwa_core.sv =====
module bwa_core (
   input  logic                 clock,
   input  logic                 reset,
   bwa_req_if.sink               in_word,
   bwa_rsp_if.source             out_word,
   input  bwa_pkg::count_type    window_samples,
   input  bwa_pkg::period_type   sample_period_ns,
   output bwa_pkg::div_req_type  div_req,
   input  bwa_pkg::div_rsp_type  div_rsp
);
   import bwa_pkg::*;

   core_state_type state_ff, state_in;
   logic           close_ff, close_in;
   logic           out_free, fire;
   logic           rsp_valid_ff, rsp_valid_in;
   interval_type   product_ff;
   period_type     period_eff;

   count_type    sample_count_ff, sample_count_in;
   sample_type   running_min_ff, running_min_in;
   sample_type   running_max_ff, running_max_in;
   sample_type   held_min_ff, held_min_in;
   sample_type   held_max_ff, held_max_in;
   logic         in_burst_ff, in_burst_in;
   count_type    burst_count_ff, burst_count_in;
   count_type    interval_sum_ff, interval_sum_in;
   count_type    last_onset_ff, last_onset_in;
   interval_type held_interval_ff, held_interval_in;

   // window state after an optional close, before the sample is applied
   count_type    base_count, base_bursts, base_sum, base_onset;
   sample_type   base_rmin, base_rmax;
   sample_type   v;
   logic signed [DET_BITS-1:0] d_ext, r_ext, d10, r9;
   count_type    gap;
   logic [COUNT_BITS:0] sum_wide;

   assign v          = in_word.voltage_sample;
   assign out_free   = !rsp_valid_ff || out_word.ready;
   assign period_eff = (sample_period_ns == '0) ? PERIOD_DEFAULT : sample_period_ns;

   // next state
   always_comb begin
      state_in = state_ff;
      close_in = close_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_word.valid) begin
               close_in = (sample_count_ff > window_samples);
               state_in = close_in ? ST_MUL : ST_EMIT;
            end
         end
         ST_MUL:    state_in = ST_DSTART;
         ST_DSTART: state_in = ST_DIV;
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      in_word.ready    = (state_ff == ST_EMIT) && out_free;
      div_req.start    = (state_ff == ST_DSTART);
      div_req.dividend = product_ff;
      div_req.divisor  = burst_count_ff;
   end

   assign fire = in_word.valid && in_word.ready;

   // window update for the sample being retired
   always_comb begin
      if (close_ff) begin
         held_min_in      = running_min_ff;
         held_max_in      = running_max_ff;
         held_interval_in = (burst_count_ff == '0) ? '0 : div_rsp.quotient;
         base_rmin        = SAMPLE_MAX;
         base_rmax        = SAMPLE_MIN;
         base_count       = '0;
         base_bursts      = '0;
         base_sum         = '0;
         base_onset       = '0;
      end else begin
         held_min_in      = held_min_ff;
         held_max_in      = held_max_ff;
         held_interval_in = held_interval_ff;
         base_rmin        = running_min_ff;
         base_rmax        = running_max_ff;
         base_count       = sample_count_ff;
         base_bursts      = burst_count_ff;
         base_sum         = interval_sum_ff;
         base_onset       = last_onset_ff;
      end

      running_min_in = (v < base_rmin) ? v : base_rmin;
      running_max_in = (v > base_rmax) ? v : base_rmax;

      d_ext = DET_BITS'(v) - DET_BITS'(held_min_in);
      r_ext = DET_BITS'(held_max_in) - DET_BITS'(held_min_in);
      d10   = (d_ext <<< 3) + (d_ext <<< 1);
      r9    = (r_ext <<< 3) + r_ext;

      gap      = (base_count >= base_onset) ? base_count - base_onset : '0;
      sum_wide = {1'b0, base_sum} + {1'b0, gap};

      in_burst_in     = in_burst_ff;
      burst_count_in  = base_bursts;
      interval_sum_in = base_sum;
      last_onset_in   = base_onset;
      if (!in_burst_ff && (d10 > r9)) begin
         in_burst_in     = 1'b1;
         burst_count_in  = (base_bursts == COUNT_MAX) ? COUNT_MAX : base_bursts + 1'b1;
         interval_sum_in = sum_wide[COUNT_BITS] ? COUNT_MAX : sum_wide[COUNT_BITS-1:0];
         last_onset_in   = base_count;
      end else if (in_burst_ff && (d10 < r_ext)) begin
         in_burst_in = 1'b0;
      end

      sample_count_in = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (out_word.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         close_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         sample_count_ff  <= '0;
         running_min_ff   <= SAMPLE_MAX;
         running_max_ff   <= SAMPLE_MIN;
         held_min_ff      <= '0;
         held_max_ff      <= '0;
         in_burst_ff      <= 1'b0;
         burst_count_ff   <= '0;
         interval_sum_ff  <= '0;
         last_onset_ff    <= '0;
         held_interval_ff <= '0;
      end else begin
         state_ff     <= state_in;
         close_ff     <= close_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            sample_count_ff  <= sample_count_in;
            running_min_ff   <= running_min_in;
            running_max_ff   <= running_max_in;
            held_min_ff      <= held_min_in;
            held_max_ff      <= held_max_in;
            in_burst_ff      <= in_burst_in;
            burst_count_ff   <= burst_count_in;
            interval_sum_ff  <= interval_sum_in;
            last_onset_ff    <= last_onset_in;
            held_interval_ff <= held_interval_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         product_ff <= INTERVAL_BITS'(interval_sum_ff) * INTERVAL_BITS'(period_eff);
      end
   end

   // held values only change on a retire, which needs a free output word
   assign out_word.valid             = rsp_valid_ff;
   assign out_word.window_min        = held_min_ff;
   assign out_word.window_max        = held_max_ff;
   assign out_word.burst_interval_ns = held_interval_ff;

endmodule

// ===== src/burst_window_analyzer_top.sv =====
// burst window analyzer
// req_word carries one signed voltage sample per word; rsp_word returns one
// word per sample with the minimum, maximum and mean onset-to-onset burst
// interval (ns) of the last completed window. the csr port writes the window
// length (index 0) and the sample period in ns (index 1); the user must write
// them only while idle, and the block itself does not enforce this.
// samples pass a two-word input queue into a sequencer that retires them
// one at a time. an ordinary sample passes the idle and emit states, and its
// word is registered in the response register as it retires. a sample that
// closes a window also passes a multiply state, a divider start state and a
// divide state that waits for the bit-serial divider's 56 quotient bits.
// the input queue keeps taking samples while the sequencer works or while
// a response waits; a stalled rsp_word holds its word and the sequencer
// stops retiring, then the queue fills and req_word.ready drops.
// synchronous reset clears the queue, empties the response register and
// restores window length 1000, period 1000000 ns and all window counters.
module burst_window_analyzer_top (
   input  logic                            clock,
   input  logic                            reset,
   bwa_req_if.sink                          req_word,
   bwa_rsp_if.source                        rsp_word,
   input  logic                            csr_we,
   input  logic [bwa_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bwa_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import bwa_pkg::*;

   count_type   window_ff;
   period_type  period_ff;
   div_req_type div_req;
   div_rsp_type div_rsp;

   bwa_req_if q_word ();

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_SAMPLES:   window_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_SAMPLE_PERIOD_NS: period_ff <= csr_wdata[PERIOD_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   bwa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_word  (req_word),
      .out_word (q_word.source)
   );

   bwa_core u_core (
      .clock            (clock),
      .reset            (reset),
      .in_word          (q_word.sink),
      .out_word         (rsp_word),
      .window_samples   (window_ff),
      .sample_period_ns (period_ff),
      .div_req          (div_req),
      .div_rsp          (div_rsp)
   );

   bwa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

endmodule

// ===== bench/burst_window_analyzer_top_tb.sv =====
module burst_window_analyzer_top_tb;
   import bwa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 4000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 80;
   localparam int IDLE_PCT = 21;
   localparam longint unsigned INTERVAL_MAX = (64'd1 << INTERVAL_BITS) - 1;

   typedef struct {
      sample_type   lo;
      sample_type   hi;
      interval_type interval;
   } window_word_type;

   // tracks the held window statistics and the words still owed by the block
   class window_tracker;
      longint unsigned window_len, period;
      longint unsigned n_samples, n_bursts, onset_sum, onset_at;
      longint          run_lo, run_hi, hold_lo, hold_hi;
      longint unsigned hold_interval;
      bit              bursting;
      window_word_type words_due[$];
      int              errors;

      function new();
         window_len = WINDOW_RESET;
         period = PERIOD_RESET;
         n_samples = 0;
         n_bursts = 0;
         onset_sum = 0;
         onset_at = 0;
         run_lo = SAMPLE_MAX;
         run_hi = SAMPLE_MIN;
         hold_lo = 0;
         hold_hi = 0;
         hold_interval = 0;
         bursting = 1'b0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         if (idx == CSR_WINDOW_SAMPLES) begin
            window_len = data[COUNT_BITS-1:0];
         end else begin
            period = data;
         end
      endfunction

      function longint unsigned count_add(longint unsigned a, longint unsigned b);
         longint unsigned s;
         s = a + b;
         return (s > COUNT_MAX) ? longint'(COUNT_MAX) : s;
      endfunction

      function void take_sample(sample_type v);
         longint          vs, span, rise;
         longint unsigned rate, quot;
         window_word_type w;
         vs = v;
         if (n_samples > window_len) begin
            rate = (period == 0) ? longint'(PERIOD_DEFAULT) : period;
            hold_lo = run_lo;
            hold_hi = run_hi;
            if (n_bursts != 0) begin
               quot = (onset_sum * rate) / n_bursts;
               hold_interval = (quot > INTERVAL_MAX) ? INTERVAL_MAX : quot;
            end else begin
               hold_interval = 0;
            end
            run_lo = SAMPLE_MAX;
            run_hi = SAMPLE_MIN;
            n_samples = 0;
            n_bursts = 0;
            onset_sum = 0;
            onset_at = 0;
         end
         if (vs < run_lo) run_lo = vs;
         if (vs > run_hi) run_hi = vs;
         span = hold_hi - hold_lo;
         rise = vs - hold_lo;
         // hysteresis: onset above 90% of the held range, offset below 10%
         if (!bursting && 10 * rise > 9 * span) begin
            bursting = 1'b1;
            n_bursts = count_add(n_bursts, 1);
            onset_sum = count_add(onset_sum,
                                  (n_samples >= onset_at) ? n_samples - onset_at : 0);
            onset_at = n_samples;
         end else if (bursting && 10 * rise < span) begin
            bursting = 1'b0;
         end
         n_samples = count_add(n_samples, 1);
         w.lo = sample_type'(hold_lo);
         w.hi = sample_type'(hold_hi);
         w.interval = interval_type'(hold_interval);
         words_due.push_back(w);
      endfunction

      function void check_word(sample_type lo, sample_type hi, interval_type ivl);
         window_word_type w;
         if (words_due.size() == 0) begin
            $error("unexpected word: min %0d max %0d interval %0d", lo, hi, ivl);
            errors++;
            return;
         end
         w = words_due.pop_front();
         if (lo !== w.lo) begin
            $error("window_min: expected %0d, got %0d", w.lo, lo);
            errors++;
         end
         if (hi !== w.hi) begin
            $error("window_max: expected %0d, got %0d", w.hi, hi);
            errors++;
         end
         if (ivl !== w.interval) begin
            $error("burst_interval_ns: expected %0d, got %0d", w.interval, ivl);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   bwa_req_if req_if ();
   bwa_rsp_if rsp_if ();

   window_tracker tracker = new();

   bit quiet_stretch = 1'b0;
   bit rsp_hold_due = 1'b0;
   int stall_cycles = 0;

   // waveform generator state
   int wave_mid = 0;
   int wave_amp = 4000;
   int wave_left = 0;
   int noise_pct = 8;
   bit wave_high = 1'b0;

   burst_window_analyzer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_if),
      .rsp_word  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5ns clock = ~clock;

   // mostly square bursts around a slowly moving level, some raw noise
   function automatic sample_type next_sample();
      int v;
      if ($urandom_range(0, 99) < noise_pct) begin
         case ($urandom_range(0, 3))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            default: return sample_type'($urandom);
         endcase
      end
      if (wave_left == 0) begin
         wave_high = !wave_high;
         wave_left = $urandom_range(1, 12);
         if ($urandom_range(0, 19) == 0) begin
            wave_mid = int'($urandom_range(0, 40000)) - 20000;
            wave_amp = int'($urandom_range(10, 16000));
         end
      end
      wave_left--;
      v = wave_mid + (wave_high ? wave_amp : -wave_amp)
          + int'($urandom_range(0, wave_amp / 8)) - wave_amp / 16;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return sample_type'(v);
   endfunction

   task automatic send_sample(input sample_type v);
      while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.voltage_sample <= v;
      do @(posedge clock); while (!req_if.ready);
      tracker.take_sample(v);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (tracker.words_due.size() != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] window_word, input logic [31:0] period_word);
      logic [31:0] win_data;
      // junk in the unused upper bits of the window register
      win_data = {8'($urandom_range(0, 255)), window_word[COUNT_BITS-1:0]};
      csr_we <= 1'b1;
      csr_index <= CSR_WINDOW_SAMPLES;
      csr_wdata <= win_data;
      tracker.set_reg(CSR_WINDOW_SAMPLES, win_data);
      @(posedge clock);
      csr_index <= CSR_SAMPLE_PERIOD_NS;
      csr_wdata <= period_word;
      tracker.set_reg(CSR_SAMPLE_PERIOD_NS, period_word);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : rsp_pacer
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_due) begin
            rsp_hold_due = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         tracker.check_word(rsp_if.window_min, rsp_if.window_max, rsp_if.burst_interval_ns);
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int n_items;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_WINDOW_SAMPLES;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.voltage_sample <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings, held range zero so any positive word starts a burst
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(16'sd0);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      drain();
      // short window, zero period falls back to the default
      configure(32'd2, 32'd0);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(16'sd0);
      drain();
      // zero window closes on every word, widest period
      configure(32'd0, 32'hFFFF_FFFF);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(16'sd5);
      send_sample(16'sd6);
      drain();
      // all-ones window never closes
      configure(32'(COUNT_MAX), 32'd1);
      send_sample(16'sd100);
      send_sample(-16'sd100);
      send_sample(16'sd100);
      send_sample(-16'sd100);
      drain();

      for (int p = 0; p < 9; p++) begin
         noise_pct = 8;
         case (p)
            0: begin configure(32'd8, PERIOD_DEFAULT); n_items = 200; end
            1: begin configure(32'd1, 32'd1); n_items = 150; end
            2: begin configure(32'd0, 32'hFFFF_FFFF); n_items = 100; end
            3: begin configure(32'd20, 32'd0); n_items = 200; noise_pct = 30; end
            4: begin configure(32'd50, $urandom); n_items = 250; end
            5: begin configure(32'd3, $urandom); n_items = 200; end
            6: begin configure(32'(COUNT_MAX), 32'd7); n_items = 100; end
            7: begin configure(32'd12, 32'hFFFF_FFFF); n_items = 200; noise_pct = 3; end
            default: begin
               configure($urandom_range(2, 40), $urandom);
               n_items = 150;
            end
         endcase
         quiet_stretch = (p == 5);
         for (int i = 0; i < n_items; i++) begin
            // long receiver stall while words keep coming, fills the input queue
            if (p == 4 && i == 30) rsp_hold_due = 1'b1;
            send_sample(next_sample());
         end
         quiet_stretch = 1'b0;
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.words_due.size() != 0) begin
         $error("%0d expected words never arrived", tracker.words_due.size());
         tracker.errors++;
      end
      if (tracker.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
